// File: design/masked_byte_pattern_scanner_defines.svh
// Assertion macros used by the scanner checker.
`ifndef MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_DEFINES_SVH

// Same-cycle implication, skipped while dis is high.
`define MBPS_ASSERT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("scanner check failed");

// Next-cycle implication, skipped while dis is high.
`define MBPS_ASSERT_NXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

// File: design/mbps_pkg.sv
package mbps_pkg;

  // Default sizes
  localparam int PATTERN_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF   = 32;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int LENGTH_BITS    = 5;
  localparam int OUT_OFFSET_BITS = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_VALUE_LO = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VALUE_HI = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MASK_LO  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MASK_HI  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTH   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST    = 3'd5;

  // Result kinds
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic [OUT_OFFSET_BITS-1:0] offset;
    logic                       found;
    logic                       last;
  } result_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: design/mbps_cell.sv
module mbps_cell import mbps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] data_byte,
  input  logic [7:0] pat_value,
  input  logic [7:0] pat_mask,
  input  logic       enable,
  input  logic       link_in,
  output logic       link_next,
  output logic       link
);

  logic hit;

  // Compare the masked byte and extend the partial match from the left neighbor
  assign hit       = (data_byte & pat_mask) == (pat_value & pat_mask);
  assign link_next = link_in & hit & enable;

  // Hold the partial-match bit; drop it at region end
  always_ff @(posedge clk) begin
    if (rst) begin
      link <= 1'b0;
    end else if (ctrl.advance) begin
      link <= ctrl.clear ? 1'b0 : link_next;
    end
  end

endmodule

// File: design/mbps_result_queue.sv
module mbps_result_queue import mbps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  input  logic       pop,
  output logic       valid,
  output result_t    head,
  output logic       almost_full
);

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);

  result_t             entries [DEPTH];
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS:0]   count;

  assign valid       = count != '0;
  assign head        = entries[rd_ptr];
  // Room for two beats must stay free before a new byte is taken
  assign almost_full = count > (PTR_BITS+1)'(DEPTH - 2);

  // Write up to two beats at the tail
  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if ((PTR_BITS'(k) - wr_ptr) == PTR_BITS'(0) && push_count != 2'd0) begin
        entries[k] <= push0;
      end else if ((PTR_BITS'(k) - wr_ptr) == PTR_BITS'(1) && push_count == 2'd2) begin
        entries[k] <= push1;
      end
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + (PTR_BITS+1)'(push_count) - (PTR_BITS+1)'(pop);
    end
  end

endmodule

// File: design/masked_byte_pattern_scanner.sv
// A byte's result beats are registered in the result queue and leave from its head.
// Throughput: one byte per cycle while each byte gives at most one result; a byte
// that ends a region with a match gives two beats, and the four-entry result queue
// stalls input once three beats are waiting.
// Reset (synchronous, active high): clears the match cells, offset, queue and
// loads register defaults (length 1, all patterns and masks zero).
module masked_byte_pattern_scanner import mbps_pkg::*; #(
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  logic [7:0]                data_byte,
  input  logic                      region_end,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      result_kind,
  output logic [OUT_OFFSET_BITS-1:0] start_offset,
  output logic                      found_any,
  output logic                      is_last
);

  localparam int IDX_BITS = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  logic [CFG_DATA_BITS-1:0]   pattern_value_lo;
  logic [CFG_DATA_BITS-1:0]   pattern_value_hi;
  logic [CFG_DATA_BITS-1:0]   pattern_mask_lo;
  logic [CFG_DATA_BITS-1:0]   pattern_mask_hi;
  logic [LENGTH_BITS-1:0]     pattern_length;
  logic                       first_only;

  logic [OFFSET_BITS-1:0]     byte_offset;
  logic                       seen_match;

  logic [2*CFG_DATA_BITS-1:0] values;
  logic [2*CFG_DATA_BITS-1:0] masks;
  logic [LENGTH_BITS-1:0]     active_len;
  logic [IDX_BITS-1:0]        last_idx;
  logic [PATTERN_BYTES-1:0]   match_vector;
  logic [PATTERN_BYTES-1:0]   match_next;
  logic [PATTERN_BYTES-1:0]   link_in;
  cell_ctrl_t                 ctrl;
  logic                       accept;
  logic                       matched;
  logic                       report;
  logic                       seen_next;
  logic [OFFSET_BITS-1:0]     back;
  logic [OFFSET_BITS-1:0]     start;
  logic [OFFSET_BITS-1:0]     count;
  result_t                    match_res;
  result_t                    end_res;
  result_t                    push0;
  logic [1:0]                 push_count;
  result_t                    head;
  logic                       almost_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_value_lo <= '0;
      pattern_value_hi <= '0;
      pattern_mask_lo  <= '0;
      pattern_mask_hi  <= '0;
      pattern_length   <= LENGTH_BITS'(1);
      first_only       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_VALUE_LO: pattern_value_lo <= cfg_data;
        CFG_VALUE_HI: pattern_value_hi <= cfg_data;
        CFG_MASK_LO:  pattern_mask_lo  <= cfg_data;
        CFG_MASK_HI:  pattern_mask_hi  <= cfg_data;
        CFG_LENGTH:   pattern_length   <= cfg_data[LENGTH_BITS-1:0];
        CFG_FIRST:    first_only       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the pattern length to 1..PATTERN_BYTES
  always_comb begin
    if (pattern_length == '0) begin
      active_len = LENGTH_BITS'(1);
    end else if (pattern_length > LENGTH_BITS'(PATTERN_BYTES)) begin
      active_len = LENGTH_BITS'(PATTERN_BYTES);
    end else begin
      active_len = pattern_length;
    end
  end

  assign last_idx = IDX_BITS'(active_len - LENGTH_BITS'(1));
  assign values   = {pattern_value_hi, pattern_value_lo};
  assign masks    = {pattern_mask_hi, pattern_mask_lo};
  assign accept   = byte_valid & ~byte_stall;
  assign ctrl     = '{advance: accept, clear: region_end};

  // Row of match cells, each passing its partial-match bit to the right
  for (genvar i = 0; i < PATTERN_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign link_in[i] = 1'b1;
    end else begin : g_link
      assign link_in[i] = match_vector[i-1];
    end
    mbps_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .data_byte (data_byte),
      .pat_value (values[8*i +: 8]),
      .pat_mask  (masks[8*i +: 8]),
      .enable    (LENGTH_BITS'(i) < active_len),
      .link_in   (link_in[i]),
      .link_next (match_next[i]),
      .link      (match_vector[i])
    );
  end

  // Match detection and offsets for this byte
  assign matched   = match_next[last_idx];
  assign report    = matched & ~(first_only & seen_match);
  assign seen_next = seen_match | matched;
  assign back      = OFFSET_BITS'(last_idx);
  assign start     = (byte_offset >= back) ? (byte_offset - back) : '0;
  assign count     = (byte_offset == OFFSET_MAX) ? OFFSET_MAX
                                                 : (byte_offset + OFFSET_BITS'(1));

  assign match_res = '{kind: KIND_MATCH, offset: OUT_OFFSET_BITS'(start),
                       found: 1'b0, last: ~region_end};
  assign end_res   = '{kind: KIND_END, offset: OUT_OFFSET_BITS'(count),
                       found: seen_next, last: 1'b1};
  assign push0     = report ? match_res : end_res;
  assign push_count = accept ? (2'(report) + 2'(region_end)) : 2'd0;

  // Offset and region flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      seen_match  <= 1'b0;
    end else if (accept) begin
      if (region_end) begin
        byte_offset <= '0;
        seen_match  <= 1'b0;
      end else begin
        seen_match <= seen_next;
        if (byte_offset != OFFSET_MAX) begin
          byte_offset <= byte_offset + OFFSET_BITS'(1);
        end
      end
    end
  end

  // Result queue toward the output channel
  mbps_result_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push0       (push0),
    .push1       (end_res),
    .pop         (result_valid & ~result_stall),
    .valid       (result_valid),
    .head        (head),
    .almost_full (almost_full)
  );

  assign byte_stall   = almost_full;
  assign result_kind  = head.kind;
  assign start_offset = head.offset;
  assign found_any    = head.found;
  assign is_last      = head.last;

endmodule

// File: design/mbps_checker.sv
`include "masked_byte_pattern_scanner_defines.svh"

module mbps_checker import mbps_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       result_valid,
  input logic                       result_stall,
  input logic                       result_kind,
  input logic [OUT_OFFSET_BITS-1:0] start_offset,
  input logic                       found_any,
  input logic                       is_last
);

  // An end beat always closes the byte's results
  `MBPS_ASSERT_IMP(a_end_is_last, clk, rst, result_valid && result_kind == KIND_END, is_last)

  // A match beat never carries the region flag
  `MBPS_ASSERT_IMP(a_match_no_found, clk, rst, result_valid && result_kind == KIND_MATCH, !found_any)

  // Output is empty right after reset
  `MBPS_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !result_valid)

  // A stalled beat holds
  `MBPS_ASSERT_NXT(a_stall_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result_kind) && $stable(start_offset) && $stable(found_any) && $stable(is_last))

endmodule

bind masked_byte_pattern_scanner mbps_checker u_checker (.*);
